@@ hw/rtl/ccst_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ccst_pkg: shared types and constants
// Character codes, scanner modes, actions and the update bundle passed from
// the scanner to the character-set store.
// ----------------------------------------------------------------------------
package ccst_pkg;

  localparam int unsigned SET_SIZE  = 95;
  localparam int unsigned ROW_W     = 16;
  localparam int unsigned ROW_COUNT = 6;
  localparam int unsigned IDX_W     = 7;
  localparam int unsigned CNT_W     = 7;

  localparam logic [7:0] CHAR_BASE  = 8'h20;
  localparam logic [7:0] CHAR_LAST  = 8'h7E;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_NL    = 8'h0A;

  // flag position of the slash character
  localparam logic [IDX_W-1:0] SLASH_IDX = 7'd15;
  localparam logic [CNT_W-1:0] FULL_CNT  = 7'd95;
  localparam logic [2:0]       ROW_LIMIT = 3'd6;

  typedef enum logic [1:0] {
    ACT_FEED    = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_READ    = 2'd2,
    ACT_NOP     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    MODE_CODE  = 3'd0,
    MODE_SLASH = 3'd1,
    MODE_LINE  = 3'd2,
    MODE_BLOCK = 3'd3,
    MODE_STAR  = 3'd4
  } mode_t;

  // one step's worth of changes to the seen flags
  typedef struct packed {
    logic             step;   // a word is processed this cycle
    logic             clear;  // restart: drop all flags and the count
    logic             slash;  // mark the held slash
    logic             chr;    // mark the current byte
    logic [IDX_W-1:0] idx;    // flag position of the current byte
  } upd_t;

endpackage : ccst_pkg
`default_nettype wire

@@ hw/rtl/ccst_scan.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ccst_scan: comment scanner
// Holds the five-mode scanner state and decides which characters to mark.
// ----------------------------------------------------------------------------
module ccst_scan (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire ccst_pkg::action_t action,
  input  wire logic [7:0]        char_byte,
  output ccst_pkg::mode_t        mode_next,
  output ccst_pkg::upd_t         upd
);

  ccst_pkg::mode_t mode;
  ccst_pkg::mode_t mode_feed;
  logic            mark_slash;
  logic            mark_chr;
  logic            printable;
  logic            feed;
  logic [7:0]      offset;

  assign feed      = (action == ccst_pkg::ACT_FEED);
  assign printable = (char_byte >= ccst_pkg::CHAR_BASE) && (char_byte <= ccst_pkg::CHAR_LAST);
  assign offset    = char_byte - ccst_pkg::CHAR_BASE;

  always_comb begin
    mode_feed  = mode;
    mark_slash = 1'b0;
    mark_chr   = 1'b0;
    unique case (mode)
      ccst_pkg::MODE_SLASH: begin
        if (char_byte == ccst_pkg::CHAR_SLASH) begin
          mode_feed = ccst_pkg::MODE_LINE;
        end else if (char_byte == ccst_pkg::CHAR_STAR) begin
          mode_feed = ccst_pkg::MODE_BLOCK;
        end else begin
          // not a comment after all: mark the slash and this byte
          mode_feed  = ccst_pkg::MODE_CODE;
          mark_slash = 1'b1;
          mark_chr   = 1'b1;
        end
      end
      ccst_pkg::MODE_LINE: begin
        if (char_byte == ccst_pkg::CHAR_NL) begin
          mode_feed = ccst_pkg::MODE_CODE;
        end
      end
      ccst_pkg::MODE_BLOCK: begin
        if (char_byte == ccst_pkg::CHAR_STAR) begin
          mode_feed = ccst_pkg::MODE_STAR;
        end
      end
      ccst_pkg::MODE_STAR: begin
        if (char_byte == ccst_pkg::CHAR_SLASH) begin
          mode_feed = ccst_pkg::MODE_CODE;
        end else if (char_byte != ccst_pkg::CHAR_STAR) begin
          mode_feed = ccst_pkg::MODE_BLOCK;
        end
      end
      default: begin
        if (char_byte == ccst_pkg::CHAR_SLASH) begin
          mode_feed = ccst_pkg::MODE_SLASH;
        end else begin
          mode_feed = ccst_pkg::MODE_CODE;
          mark_chr  = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    if (feed) begin
      mode_next = mode_feed;
    end else if (action == ccst_pkg::ACT_RESTART) begin
      mode_next = ccst_pkg::MODE_CODE;
    end else begin
      mode_next = mode;
    end
  end

  assign upd.step  = step;
  assign upd.clear = (action == ccst_pkg::ACT_RESTART);
  assign upd.slash = feed && mark_slash;
  assign upd.chr   = feed && mark_chr && printable;
  assign upd.idx   = printable ? offset[ccst_pkg::IDX_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ccst_pkg::MODE_CODE;
    end else if (step) begin
      mode <= mode_next;
    end
  end

endmodule : ccst_scan
`default_nettype wire

@@ hw/rtl/ccst_charset.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ccst_charset: seen-character store
// Holds the 95 seen flags and their distinct count, and reads one row.
// ----------------------------------------------------------------------------
module ccst_charset (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ccst_pkg::upd_t                upd,
  input  wire logic                          rd_en,
  input  wire logic [2:0]                    row_select,
  output logic      [ccst_pkg::CNT_W-1:0]    count_next,
  output logic      [ccst_pkg::ROW_W-1:0]    row_flags
);

  logic [ccst_pkg::SET_SIZE-1:0]                 flags;
  logic [ccst_pkg::SET_SIZE-1:0]                 flags_next;
  logic [ccst_pkg::CNT_W-1:0]                    count;
  logic                                          inc_slash;
  logic                                          inc_chr;
  logic [ccst_pkg::ROW_W*ccst_pkg::ROW_COUNT-1:0] padded;
  logic [6:0]                                    row_base;

  assign inc_slash = upd.slash && !flags[ccst_pkg::SLASH_IDX];
  // a byte equal to the held slash counts only once
  assign inc_chr   = upd.chr && !flags[upd.idx] &&
                     !(upd.slash && (upd.idx == ccst_pkg::SLASH_IDX));

  always_comb begin
    flags_next = flags;
    if (upd.clear) begin
      flags_next = '0;
    end else begin
      if (upd.slash) begin
        flags_next[ccst_pkg::SLASH_IDX] = 1'b1;
      end
      if (upd.chr) begin
        flags_next[upd.idx] = 1'b1;
      end
    end
  end

  assign count_next = upd.clear ? '0
                    : count + {{(ccst_pkg::CNT_W-1){1'b0}}, inc_slash}
                            + {{(ccst_pkg::CNT_W-1){1'b0}}, inc_chr};

  // the last row has one missing character; pad it with zero
  assign padded   = {1'b0, flags};
  assign row_base = {row_select, 4'b0000};
  assign row_flags = (rd_en && (row_select < ccst_pkg::ROW_LIMIT))
                   ? padded[row_base +: ccst_pkg::ROW_W] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
      count <= '0;
    end else if (upd.step) begin
      flags <= flags_next;
      count <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_count_matches_flags: assert property (@(posedge clk) disable iff (rst)
    $countones(flags) == int'(count))
    else $error("distinct count disagrees with seen flags");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= ccst_pkg::FULL_CNT)
    else $error("distinct count above set size");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (upd.step && upd.clear) |=> (count == '0) && (flags == '0))
    else $error("restart left flags or count set");

  a_no_change_idle: assert property (@(posedge clk) disable iff (rst)
    !upd.step |=> $stable(flags) && $stable(count))
    else $error("store changed without a step");
`endif

endmodule : ccst_charset
`default_nettype wire

@@ hw/rtl/comment_skipping_charset_tracker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// comment_skipping_charset_tracker: charset tracker for C-style source text
// Scans source bytes, skips line and block comments, and tracks which
// printable characters appear outside them.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one word per step. tuser carries the action
//   (feed byte, restart, read row, no operation); tdata carries the byte
//   and the row select. Output stream (m_axis_*): exactly one result word
//   per input word, in order, showing the state after that word: distinct
//   count, pangram flag, scanner mode and, for a row read, 16 seen flags.
//   Path: a word accepted into the input register is processed by the
//   scanner and the flag store, and its result is captured in the result
//   register that drives m_axis.
//   Throughput: one word per cycle, sustained, while m_axis_tready is high;
//   the combinational scanner and flag update set that figure.
//   Stall: while a result waits for m_axis_tready the input register still
//   takes one more word; s_axis_tready drops only when both registers hold.
//   Reset (rst, synchronous): clears the flags, the count, the mode and
//   both valid bits. A restart word does the same to the tracker state.
// ----------------------------------------------------------------------------
module comment_skipping_charset_tracker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // char_byte[7:0], row_select[10:8], zero[15:11]
  input  wire logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata   // used_count[6:0], is_pangram[7],
                                          // scan_mode[10:8], row_flags[26:11],
                                          // zero[31:27]
);

  // input register
  logic              in_valid;
  ccst_pkg::action_t in_action;
  logic [7:0]        in_byte;
  logic [2:0]        in_row;

  // result register
  logic                          out_valid;
  logic [ccst_pkg::CNT_W-1:0]    out_count;
  logic                          out_pangram;
  ccst_pkg::mode_t               out_mode;
  logic [ccst_pkg::ROW_W-1:0]    out_row;

  logic                          out_free;
  logic                          step;
  ccst_pkg::mode_t               mode_next;
  ccst_pkg::upd_t                upd;
  logic [ccst_pkg::CNT_W-1:0]    count_next;
  logic [ccst_pkg::ROW_W-1:0]    row_flags;

  // advance the held word when the result slot is empty or being drained
  assign out_free      = !out_valid || m_axis_tready;
  assign step          = in_valid && out_free;
  assign s_axis_tready = !in_valid || step;

  ccst_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .action    (in_action),
    .char_byte (in_byte),
    .mode_next (mode_next),
    .upd       (upd)
  );

  ccst_charset u_charset (
    .clk        (clk),
    .rst        (rst),
    .upd        (upd),
    .rd_en      (in_action == ccst_pkg::ACT_READ),
    .row_select (in_row),
    .count_next (count_next),
    .row_flags  (row_flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
    end
    // payload: capture on accept, hold otherwise
    if (s_axis_tvalid && s_axis_tready) begin
      in_action <= ccst_pkg::action_t'(s_axis_tuser);
      in_byte   <= s_axis_tdata[7:0];
      in_row    <= s_axis_tdata[10:8];
    end
    if (step) begin
      out_count   <= count_next;
      out_pangram <= (count_next == ccst_pkg::FULL_CNT);
      out_mode    <= mode_next;
      out_row     <= row_flags;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b00000, out_row, out_mode, out_pangram, out_count};

`ifndef SYNTHESIS
  a_result_held_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |=> out_valid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_pangram_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_pangram == (out_count == ccst_pkg::FULL_CNT)))
    else $error("pangram flag disagrees with count");

  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (m_axis_tdata[10:8] <= ccst_pkg::MODE_STAR))
    else $error("illegal scanner mode reported");
`endif

endmodule : comment_skipping_charset_tracker
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for comment_skipping_charset_tracker
// Sends a short table of hand-picked words, then random source text built
// from code runs, line and block comments, broken slashes, noise bytes, row
// reads and restarts. Every result word is matched against a local model of
// the scanner and the seen-flag store, with random stalls on both streams.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RANDOM_WORDS = 1200;

  // one result word, unpacked
  typedef struct {
    logic [6:0]      count;
    logic            pangram;
    ccst_pkg::mode_t mode;
    logic [15:0]     flags;
  } tally_t;

  typedef struct {
    ccst_pkg::action_t act;
    logic [7:0]        chr;
    logic [2:0]        row;
    bit                typed;  // want holds a hand-written result
    tally_t            want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // char_byte[7:0], row_select[10:8], zero[15:11]
  logic [1:0]  s_axis_tuser = ccst_pkg::ACT_NOP;  // action[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // used_count[6:0], is_pangram[7], scan_mode[10:8],
                              // row_flags[26:11], zero[31:27]

  // local copy of the tracker state
  ccst_pkg::mode_t scan_state = ccst_pkg::MODE_CODE;
  bit [94:0]       seen_chars = '0;
  int              seen_total = 0;

  tally_t      pending_tallies[$];
  int          words_sent = 0;
  int          results_seen = 0;
  int          bad_words = 0;
  int          burst_left = 0;

  comment_skipping_charset_tracker dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // generous ceiling on the whole run
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // set the flag of a printable character, bump the count on first sight
  function automatic void mark_seen(logic [7:0] c);
    if (c >= ccst_pkg::CHAR_BASE && c <= ccst_pkg::CHAR_LAST &&
        !seen_chars[c - ccst_pkg::CHAR_BASE]) begin
      seen_chars[c - ccst_pkg::CHAR_BASE] = 1'b1;
      seen_total++;
    end
  endfunction

  // advance the local tracker by one word and return the result it shows
  function automatic tally_t tally_after(ccst_pkg::action_t act, logic [7:0] c,
                                         logic [2:0] row);
    tally_t t;
    int     idx;
    t.flags = '0;
    case (act)
      ccst_pkg::ACT_FEED: begin
        case (scan_state)
          ccst_pkg::MODE_SLASH: begin
            if (c == ccst_pkg::CHAR_SLASH) scan_state = ccst_pkg::MODE_LINE;
            else if (c == ccst_pkg::CHAR_STAR) scan_state = ccst_pkg::MODE_BLOCK;
            else begin
              // the slash opened nothing: it counts, and so does this byte
              scan_state = ccst_pkg::MODE_CODE;
              mark_seen(ccst_pkg::CHAR_SLASH);
              mark_seen(c);
            end
          end
          ccst_pkg::MODE_LINE: if (c == ccst_pkg::CHAR_NL) scan_state = ccst_pkg::MODE_CODE;
          ccst_pkg::MODE_BLOCK: if (c == ccst_pkg::CHAR_STAR) scan_state = ccst_pkg::MODE_STAR;
          ccst_pkg::MODE_STAR: begin
            if (c == ccst_pkg::CHAR_SLASH) scan_state = ccst_pkg::MODE_CODE;
            else if (c != ccst_pkg::CHAR_STAR) scan_state = ccst_pkg::MODE_BLOCK;
          end
          default: begin
            scan_state = ccst_pkg::MODE_CODE;
            if (c == ccst_pkg::CHAR_SLASH) scan_state = ccst_pkg::MODE_SLASH;
            else mark_seen(c);
          end
        endcase
      end
      ccst_pkg::ACT_RESTART: begin
        scan_state = ccst_pkg::MODE_CODE;
        seen_chars = '0;
        seen_total = 0;
      end
      ccst_pkg::ACT_READ: begin
        if (row < 3'd6) begin
          for (int j = 0; j < 16; j++) begin
            idx = int'(row) * 16 + j;
            if (idx < 95 && seen_chars[idx]) t.flags[j] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    t.count   = 7'(seen_total);
    t.pangram = (seen_total == 95);
    t.mode    = scan_state;
    return t;
  endfunction

  // offer one word, hold it until taken, then queue what it should produce;
  // valid stays high after the handshake so back-to-back words need no dip
  task automatic offer(ccst_pkg::action_t act, logic [7:0] c, logic [2:0] row,
                       bit typed, tally_t want);
    int     gap;
    int     pick;
    tally_t t;
    gap  = 0;
    pick = $urandom_range(0, 99);
    if (burst_left > 0) burst_left--;
    else if (pick < 2) burst_left = $urandom_range(20, 60);
    else if (pick < 55) gap = 0;
    else if (pick < 88) gap = $urandom_range(1, 3);
    else if (pick < 97) gap = $urandom_range(4, 9);
    else gap = $urandom_range(15, 40);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {5'b0, row, c};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    t = tally_after(act, c, row);
    pending_tallies.push_back(typed ? want : t);
    words_sent++;
  endtask

  task automatic wait_drained();
    while (pending_tallies.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, calm runs, and two long hold-offs that back
  // the block up into its input
  initial begin : sink
    int hold_left;
    int calm_left;
    int long_done;
    int pick;
    hold_left = 0;
    calm_left = 0;
    long_done = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      pick = $urandom_range(0, 99);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (long_done < 2 && results_seen >= 300 + 600 * long_done) begin
        long_done++;
        hold_left = 60;
        m_axis_tready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        m_axis_tready <= 1'b1;
      end else if (pick < 3) begin
        calm_left = $urandom_range(30, 80);
        m_axis_tready <= 1'b1;
      end else if (pick < 5) begin
        hold_left = $urandom_range(8, 30);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (pick < 75);
      end
    end
  end

  // compare each result word with the oldest queued tally
  always @(posedge clk) begin
    tally_t want;
    tally_t got;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      results_seen++;
      got.count   = m_axis_tdata[6:0];
      got.pangram = m_axis_tdata[7];
      got.mode    = ccst_pkg::mode_t'(m_axis_tdata[10:8]);
      got.flags   = m_axis_tdata[26:11];
      if (pending_tallies.size() == 0) begin
        bad_words++;
        if (bad_words <= 10)
          $display("unexpected result word %h at %0t", m_axis_tdata, $realtime);
      end else begin
        want = pending_tallies.pop_front();
        if (got.count !== want.count || got.pangram !== want.pangram ||
            got.mode !== want.mode || got.flags !== want.flags ||
            m_axis_tdata[31:27] !== 5'b0) begin
          bad_words++;
          if (bad_words <= 10)
            $display({"result %0d: want cnt=%0d pan=%0b mode=%0d row=%h, ",
                      "got cnt=%0d pan=%0b mode=%0d row=%h pad=%b"},
                     results_seen, want.count, want.pangram, want.mode, want.flags,
                     got.count, got.pangram, got.mode, got.flags, m_axis_tdata[31:27]);
        end
      end
    end
  end

  initial begin : source
    plan_row_t  plan[25];
    tally_t     none;
    tally_t     zero_code;
    int         pick;
    int         len;
    int         r;
    bit         drained_mid;
    logic [7:0] c;
    none        = '{default: '0, mode: ccst_pkg::MODE_CODE};
    zero_code   = '{count: 7'd0, pangram: 1'b0, mode: ccst_pkg::MODE_CODE, flags: 16'h0};
    drained_mid = 1'b0;
    plan = '{
      // empty state after reset, seen through a no-op and a row read
      '{ccst_pkg::ACT_NOP,     8'h00,                3'd0, 1'b1, zero_code},
      '{ccst_pkg::ACT_READ,    8'h00,                3'd0, 1'b1, zero_code},
      // lowest and highest printable, then bytes outside the range
      '{ccst_pkg::ACT_FEED,    8'h20,                3'd7, 1'b1,
        '{7'd1, 1'b0, ccst_pkg::MODE_CODE, 16'h0}},
      '{ccst_pkg::ACT_FEED,    8'h7E,                3'd0, 1'b1,
        '{7'd2, 1'b0, ccst_pkg::MODE_CODE, 16'h0}},
      '{ccst_pkg::ACT_FEED,    8'h1F,                3'd0, 1'b1,
        '{7'd2, 1'b0, ccst_pkg::MODE_CODE, 16'h0}},
      '{ccst_pkg::ACT_FEED,    8'hFF,                3'd0, 1'b1,
        '{7'd2, 1'b0, ccst_pkg::MODE_CODE, 16'h0}},
      // a lone slash, then a letter: both get marked
      '{ccst_pkg::ACT_FEED,    ccst_pkg::CHAR_SLASH, 3'd0, 1'b1,
        '{7'd2, 1'b0, ccst_pkg::MODE_SLASH, 16'h0}},
      '{ccst_pkg::ACT_FEED,    8'h61,                3'd0, 1'b0, none},
      // line comment closed by newline
      '{ccst_pkg::ACT_FEED,    ccst_pkg::CHAR_SLASH, 3'd0, 1'b0, none},
      '{ccst_pkg::ACT_FEED,    ccst_pkg::CHAR_SLASH, 3'd0, 1'b0, none},
      '{ccst_pkg::ACT_FEED,    8'h62,                3'd0, 1'b0, none},
      '{ccst_pkg::ACT_FEED,    ccst_pkg::CHAR_NL,    3'd0, 1'b0, none},
      // block comment with a false star, a star run and a proper close
      '{ccst_pkg::ACT_FEED,    ccst_pkg::CHAR_SLASH, 3'd0, 1'b0, none},
      '{ccst_pkg::ACT_FEED,    ccst_pkg::CHAR_STAR,  3'd0, 1'b0, none},
      '{ccst_pkg::ACT_FEED,    8'h63,                3'd0, 1'b0, none},
      '{ccst_pkg::ACT_FEED,    ccst_pkg::CHAR_STAR,  3'd0, 1'b0, none},
      '{ccst_pkg::ACT_FEED,    ccst_pkg::CHAR_STAR,  3'd0, 1'b0, none},
      '{ccst_pkg::ACT_FEED,    8'h64,                3'd0, 1'b0, none},
      '{ccst_pkg::ACT_FEED,    ccst_pkg::CHAR_STAR,  3'd0, 1'b0, none},
      '{ccst_pkg::ACT_FEED,    ccst_pkg::CHAR_SLASH, 3'd0, 1'b0, none},
      // slash followed by an unprintable byte: only the slash counts
      '{ccst_pkg::ACT_FEED,    ccst_pkg::CHAR_SLASH, 3'd0, 1'b0, none},
      '{ccst_pkg::ACT_FEED,    8'h00,                3'd0, 1'b0, none},
      // last row, out-of-range row, restart
      '{ccst_pkg::ACT_READ,    8'hFF,                3'd5, 1'b0, none},
      '{ccst_pkg::ACT_READ,    8'h00,                3'd7, 1'b0, none},
      '{ccst_pkg::ACT_RESTART, 8'h55,                3'd2, 1'b1, zero_code}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i])
      offer(plan[i].act, plan[i].chr, plan[i].row, plan[i].typed, plan[i].want);

    // random source text, mostly well formed
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        len = $urandom_range(1, 12);
        repeat (len)
          offer(ccst_pkg::ACT_FEED, 8'($urandom_range(32, 126)), 3'($urandom), 1'b0, none);
      end else if (pick < 55) begin
        offer(ccst_pkg::ACT_FEED, ccst_pkg::CHAR_SLASH, 3'($urandom), 1'b0, none);
        offer(ccst_pkg::ACT_FEED, ccst_pkg::CHAR_SLASH, 3'($urandom), 1'b0, none);
        len = $urandom_range(0, 10);
        repeat (len)
          offer(ccst_pkg::ACT_FEED, 8'($urandom_range(0, 255)), 3'($urandom), 1'b0, none);
        offer(ccst_pkg::ACT_FEED, ccst_pkg::CHAR_NL, 3'($urandom), 1'b0, none);
      end else if (pick < 67) begin
        offer(ccst_pkg::ACT_FEED, ccst_pkg::CHAR_SLASH, 3'($urandom), 1'b0, none);
        offer(ccst_pkg::ACT_FEED, ccst_pkg::CHAR_STAR, 3'($urandom), 1'b0, none);
        len = $urandom_range(0, 12);
        repeat (len) begin
          r = $urandom_range(0, 9);
          c = (r < 3) ? ccst_pkg::CHAR_STAR :
              (r < 5) ? ccst_pkg::CHAR_SLASH : 8'($urandom_range(0, 255));
          offer(ccst_pkg::ACT_FEED, c, 3'($urandom), 1'b0, none);
        end
        // drop the close now and then so the comment runs into what follows
        if ($urandom_range(0, 7) != 0) begin
          offer(ccst_pkg::ACT_FEED, ccst_pkg::CHAR_STAR, 3'($urandom), 1'b0, none);
          offer(ccst_pkg::ACT_FEED, ccst_pkg::CHAR_SLASH, 3'($urandom), 1'b0, none);
        end
      end else if (pick < 75) begin
        len = $urandom_range(1, 6);
        repeat (len)
          offer(ccst_pkg::ACT_FEED, 8'($urandom_range(0, 255)), 3'($urandom), 1'b0, none);
      end else if (pick < 88) begin
        offer(ccst_pkg::ACT_READ, 8'($urandom), 3'($urandom_range(0, 7)), 1'b0, none);
      end else if (pick < 93) begin
        offer(ccst_pkg::ACT_NOP, 8'($urandom), 3'($urandom), 1'b0, none);
      end else if (pick < 95) begin
        // restart mostly once the set is nearly full, so a pangram shows up
        if (seen_total >= 80 || $urandom_range(0, 5) == 0)
          offer(ccst_pkg::ACT_RESTART, 8'($urandom), 3'($urandom), 1'b0, none);
        else
          offer(ccst_pkg::ACT_NOP, 8'($urandom), 3'($urandom), 1'b0, none);
      end else begin
        // broken opener: slash then anything
        offer(ccst_pkg::ACT_FEED, ccst_pkg::CHAR_SLASH, 3'($urandom), 1'b0, none);
        offer(ccst_pkg::ACT_FEED, 8'($urandom_range(0, 255)), 3'($urandom), 1'b0, none);
      end

      // pause the sender once until every result is back
      if (!drained_mid && words_sent >= RANDOM_WORDS / 2) begin
        drained_mid = 1'b1;
        s_axis_tvalid <= 1'b0;
        wait_drained();
      end
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (bad_words == 0 && pending_tallies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
